// ===== hdl/gft_pkg.sv =====
// package: shared types and codes for the gnss fix trust state machine
`default_nettype none

package gft_pkg;

  // trust states
  typedef enum logic [2:0] {
    ST_LOCAL  = 3'd0,
    ST_CAND   = 3'd1,
    ST_LOCKED = 3'd2,
    ST_DEGR   = 3'd3,
    ST_RECOV  = 3'd4,
    ST_FAULT  = 3'd5
  } trust_state_t;

  // event codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_REJECT = 2'd2,
    MODE_FRESET = 2'd3
  } mode_t;

  // sample classes
  typedef enum logic [1:0] {
    CLS_STRONG   = 2'd0,
    CLS_WEAK     = 2'd1,
    CLS_DIAG     = 2'd2,
    CLS_REJECTED = 2'd3
  } gate_class_t;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_THR  = 2'd1;

  localparam int unsigned OUT_COUNT_W = 16;
  localparam logic [CFG_DATA_W-1:0] THR_RESET = 16'd5;

  // threshold registers as seen by the next-state logic
  typedef struct packed {
    logic [CFG_DATA_W-1:0] recovery_thr;
    logic [CFG_DATA_W-1:0] degrade_thr;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/gft_next.sv =====
// next-state logic: one event applied to the registered trust state and counts
`default_nettype none

module gft_next
  import gft_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  trust_state_t           state_q,
  input  logic [COUNT_WIDTH-1:0] strong_q,
  input  logic [COUNT_WIDTH-1:0] invalid_q,
  input  mode_t                  mode,
  input  gate_class_t            gate_class,
  input  logic                   residual_ok,
  input  cfg_t                   cfg,
  output trust_state_t           state_d,
  output logic [COUNT_WIDTH-1:0] strong_d,
  output logic [COUNT_WIDTH-1:0] invalid_d
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_WIDTH{1'b1}});

  logic [COUNT_WIDTH-1:0] strong_inc;
  logic [COUNT_WIDTH-1:0] invalid_inc;
  logic [COUNT_WIDTH-1:0] commit_load;
  logic                   rec_met;
  logic                   deg_met;
  trust_state_t           dropped;
  trust_state_t           strong_state;

  // saturating increments
  assign strong_inc  = (&strong_q)  ? strong_q  : strong_q  + 1'b1;
  assign invalid_inc = (&invalid_q) ? invalid_q : invalid_q + 1'b1;

  assign rec_met = CMP_W'(strong_inc)  >= CMP_W'(cfg.recovery_thr);
  assign deg_met = CMP_W'(invalid_inc) >= CMP_W'(cfg.degrade_thr);

  // threshold clipped to the count range
  assign commit_load = (CMP_W'(cfg.recovery_thr) > COUNT_MAX) ?
                       {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(cfg.recovery_thr);

  always_comb begin
    unique case (state_q)
      ST_LOCKED:          dropped = ST_DEGR;
      ST_CAND, ST_RECOV:  dropped = ST_LOCAL;
      default:            dropped = state_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_LOCAL || state_q == ST_DEGR || state_q == ST_CAND) begin
      strong_state = rec_met ? ST_RECOV : ST_CAND;
    end else begin
      strong_state = state_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    strong_d  = strong_q;
    invalid_d = invalid_q;
    unique case (mode)
      MODE_SAMPLE: begin
        if (state_q != ST_FAULT) begin
          priority if (gate_class == CLS_STRONG && !residual_ok) begin
            state_d  = ST_FAULT;
            strong_d = '0;
          end else if (gate_class == CLS_STRONG) begin
            state_d   = strong_state;
            strong_d  = strong_inc;
            invalid_d = '0;
          end else if (gate_class == CLS_REJECTED) begin
            strong_d  = '0;
            invalid_d = invalid_inc;
            if (state_q == ST_DEGR) begin
              state_d = deg_met ? ST_LOCAL : ST_DEGR;
            end else begin
              state_d = dropped;
            end
          end else begin
            strong_d = '0;
            state_d  = dropped;
          end
        end
      end
      MODE_COMMIT: begin
        if (state_q == ST_RECOV) begin
          state_d   = ST_LOCKED;
          strong_d  = commit_load;
          invalid_d = '0;
        end
      end
      MODE_REJECT: begin
        state_d   = dropped;
        strong_d  = '0;
        invalid_d = '0;
      end
      MODE_FRESET: begin
        if (state_q == ST_FAULT) begin
          state_d   = ST_LOCAL;
          strong_d  = '0;
          invalid_d = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gft_out_reg.sv =====
// result register: holds one result beat until the consumer takes it
`default_nettype none

module gft_out_reg
  import gft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  trust_state_t           state_d,
  input  logic [OUT_COUNT_W-1:0] strong_d,
  input  logic [OUT_COUNT_W-1:0] invalid_d,
  output logic                   slot_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_trust_state,
  output logic [OUT_COUNT_W-1:0] out_strong_count,
  output logic [OUT_COUNT_W-1:0] out_invalid_count
);

  logic                   valid_r;
  trust_state_t           state_r;
  logic [OUT_COUNT_W-1:0] strong_r;
  logic [OUT_COUNT_W-1:0] invalid_r;

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      state_r   <= state_d;
      strong_r  <= strong_d;
      invalid_r <= invalid_d;
    end
  end

  assign out_valid         = valid_r;
  assign out_trust_state   = state_r;
  assign out_strong_count  = strong_r;
  assign out_invalid_count = invalid_r;

endmodule

`default_nettype wire

// ===== hdl/gnss_fix_trust_state_machine_top.sv =====
// top level: gnss fix trust state machine with config registers and result register
`default_nettype none

// Trust state machine for RTK position fixes. Each input beat carries one
// event (gated sample, recovery committed, recovery rejected, fault reset)
// and yields exactly one result beat with the new trust state and the
// strong and invalid run counts, which saturate at 2^COUNT_WIDTH-1 and show
// their low 16 bits. One event is accepted every cycle unless in_ready is low: the
// next state is computed in one combinational pass from the state registers and
// the input beat, and lands in the state registers and the result register at
// the same edge, so a result appears in the cycle after its input is accepted.
// in_ready is low during reset and until run_r is set after it; after that
// it drops only while the result register is full and not being taken.
// Thresholds are written through the cfg_ channel (index 0 recovery
// threshold, index 1 degrade threshold, others ignored), both reset to 5,
// and must be written only while no event is in flight.

module gnss_fix_trust_state_machine_top
  import gft_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // event channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [1:0]             in_gate_class,
  input  logic                   in_residual_ok,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_trust_state,
  output logic [OUT_COUNT_W-1:0] out_strong_count,
  output logic [OUT_COUNT_W-1:0] out_invalid_count,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // ready only after reset has been released
  logic run_r;

  // threshold registers
  cfg_t cfg_r;

  // trust state and run counters
  trust_state_t           state_r;
  logic [COUNT_WIDTH-1:0] strong_r;
  logic [COUNT_WIDTH-1:0] invalid_r;

  trust_state_t           state_nxt;
  logic [COUNT_WIDTH-1:0] strong_nxt;
  logic [COUNT_WIDTH-1:0] invalid_nxt;

  logic slot_free;
  logic in_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= 1'b1;
    end
  end

  assign in_ready  = run_r && slot_free;
  assign cfg_ready = run_r;
  assign in_beat   = in_valid && in_ready;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recovery_thr <= THR_RESET;
      cfg_r.degrade_thr  <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RECOVERY_THR) begin
        cfg_r.recovery_thr <= cfg_wdata;
      end
      if (cfg_index == CFG_DEGRADE_THR) begin
        cfg_r.degrade_thr <= cfg_wdata;
      end
    end
  end

  gft_next #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_next (
    .state_q     (state_r),
    .strong_q    (strong_r),
    .invalid_q   (invalid_r),
    .mode        (mode_t'(in_mode)),
    .gate_class  (gate_class_t'(in_gate_class)),
    .residual_ok (in_residual_ok),
    .cfg         (cfg_r),
    .state_d     (state_nxt),
    .strong_d    (strong_nxt),
    .invalid_d   (invalid_nxt)
  );

  // state advances only on an accepted event beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOCAL;
      strong_r  <= '0;
      invalid_r <= '0;
    end else if (in_beat) begin
      state_r   <= state_nxt;
      strong_r  <= strong_nxt;
      invalid_r <= invalid_nxt;
    end
  end

  // result register takes the same next values, low 16 bits of the counts
  gft_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (in_beat),
    .state_d           (state_nxt),
    .strong_d          (OUT_COUNT_W'(strong_nxt)),
    .invalid_d         (OUT_COUNT_W'(invalid_nxt)),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trust_state   (out_trust_state),
    .out_strong_count  (out_strong_count),
    .out_invalid_count (out_invalid_count)
  );

endmodule

`default_nettype wire

// ===== hdl/gft_checker.sv =====
// checker: port-level properties of the trust state machine, bound to the top level
`default_nettype none

module gft_checker
  import gft_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [2:0]             out_trust_state,
  input wire logic [OUT_COUNT_W-1:0] out_strong_count
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // every accepted event gives a result beat in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted event gave no result beat");

  // no new event while the result register is full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("event accepted over a stalled result");

  // fault hold always carries a cleared strong run
  a_fault_strong: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trust_state == ST_FAULT |-> out_strong_count == '0)
    else $error("strong run nonzero in fault hold");

endmodule

bind gnss_fix_trust_state_machine_top gft_checker u_gft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_trust_state  (out_trust_state),
  .out_strong_count (out_strong_count)
);

`default_nettype wire
